FILE: hw/rtl/sha1md_pkg.sv
// shared types and constants for the sha-1 message digest block
// no dependencies; imported by every module of the block
package sha1md_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        final_word;
    } t_out_item;

    typedef logic [0:4][31:0] t_hash;

    typedef struct packed {
        logic shift_byte;
        logic shift_word;
    } t_sched_ctl;

    typedef struct packed {
        logic load;
        logic step;
    } t_round_ctl;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROUND = 6'b000010,
        S_ADD   = 6'b000100,
        S_PAD   = 6'b001000,
        S_LEN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam t_hash H_INIT = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                32'h10325476, 32'hC3D2E1F0};

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] PRE_LEN_POS = 6'd55;
    localparam logic [7:0] PAD_FIRST  = 8'h80;
    localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

FILE: hw/rtl/sha1md_sched.sv
// 512-bit block buffer and message schedule shift line
// depends on sha1md_pkg
module sha1md_sched (
    input  logic                   i_clk,
    input  sha1md_pkg::t_sched_ctl i_ctl,
    input  logic [7:0]             i_byte,
    output logic [31:0]            o_w0
);
    import sha1md_pkg::*;

    logic [511:0] r_blk;
    logic [31:0]  w_mix;
    logic [31:0]  w_new;

    // taps at words 13, 8, 2, 0 of the line
    assign w_mix = r_blk[511-32*13 -: 32] ^ r_blk[511-32*8 -: 32]
                 ^ r_blk[511-32*2 -: 32] ^ r_blk[511 -: 32];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign o_w0  = r_blk[511 -: 32];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_byte) begin
            r_blk <= {r_blk[503:0], i_byte};
        end else if (i_ctl.shift_word) begin
            r_blk <= {r_blk[479:0], w_new};
        end
    end

endmodule

FILE: hw/rtl/sha1md_round.sv
// one sha-1 round per cycle over the working variables a..e
// depends on sha1md_pkg
module sha1md_round (
    input  logic                   i_clk,
    input  sha1md_pkg::t_round_ctl i_ctl,
    input  logic [6:0]             i_round,
    input  sha1md_pkg::t_hash      i_h,
    input  logic [31:0]            i_w,
    output sha1md_pkg::t_hash      o_abcde
);
    import sha1md_pkg::*;

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] w_f, w_k, w_t;

    always_comb begin
        if (i_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_R0;
        end else if (i_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_R1;
        end else if (i_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_R2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_R3;
        end
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + i_w;
    assign o_abcde = {r_a, r_b, r_c, r_d, r_e};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_h[0];
            r_b <= i_h[1];
            r_c <= i_h[2];
            r_d <= i_h[3];
            r_e <= i_h[4];
        end else if (i_ctl.step) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_t;
        end
    end

endmodule

FILE: hw/rtl/sha1_message_digest.sv
// sha-1 over a byte stream: one byte per item, digest out as five word items
// each 64-byte block is compressed in 80 rounds, then added into the hash words
// closing: 0x80 and zero padding plus eight length bytes, with one or two compressions
// the single round unit sets the rate; input is not ready while a block is compressed
// output: five items, one per accepted cycle; input not ready until the last
// reset (synchronous, active low): hash words to initial values, count to zero
// depends on sha1md_pkg, sha1md_sched, sha1md_round
module sha1_message_digest (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha1md_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sha1md_pkg::t_out_item o_out_data
);
    import sha1md_pkg::*;

    t_state      r_state, n_state;
    t_hash       r_h, n_h;
    logic [63:0] r_cnt, n_cnt;
    logic [5:0]  r_pos, n_pos;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;
    logic        r_last, n_last;
    logic        r_sent80, n_sent80;
    logic        r_final, n_final;

    t_sched_ctl  w_sctl;
    t_round_ctl  w_rctl;
    logic [7:0]  w_byte;
    logic [31:0] w_w0;
    t_hash       w_abcde;

    sha1md_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (w_sctl),
        .i_byte (w_byte),
        .o_w0   (w_w0)
    );

    sha1md_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (w_rctl),
        .i_round (r_round),
        .i_h     (r_h),
        .i_w     (w_w0),
        .o_abcde (w_abcde)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data.digest_word = r_h[r_idx];
    assign o_out_data.word_index  = r_idx;
    assign o_out_data.final_word  = (r_idx == LAST_WORD);

    always_comb begin
        n_state  = r_state;
        n_h      = r_h;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_round  = r_round;
        n_idx    = r_idx;
        n_last   = r_last;
        n_sent80 = r_sent80;
        n_final  = r_final;
        w_sctl   = '0;
        w_rctl   = '0;
        w_byte   = i_in_data.data_byte;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_in_data.last;
                    if (i_in_data.byte_valid) begin
                        w_sctl.shift_byte = 1'b1;
                        n_cnt = r_cnt + 64'd8;
                        n_pos = r_pos + 6'd1;
                        if (r_pos == LAST_POS) begin
                            w_rctl.load = 1'b1;
                            n_round = '0;
                            n_state = S_ROUND;
                        end else if (i_in_data.last) begin
                            n_state = S_PAD;
                        end
                    end else if (i_in_data.last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                w_rctl.step = 1'b1;
                w_sctl.shift_word = 1'b1;
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    n_h[i] = r_h[i] + w_abcde[i];
                end
                if (r_final) begin
                    n_idx = '0;
                    n_state = S_OUT;
                end else if (r_last) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                w_sctl.shift_byte = 1'b1;
                w_byte = r_sent80 ? 8'h00 : PAD_FIRST;
                n_sent80 = 1'b1;
                n_pos = r_pos + 6'd1;
                if (r_pos == LAST_POS) begin
                    w_rctl.load = 1'b1;
                    n_round = '0;
                    n_state = S_ROUND;
                end else if (r_pos == PRE_LEN_POS) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                w_sctl.shift_byte = 1'b1;
                w_byte = r_cnt[63:56];
                n_cnt = {r_cnt[55:0], 8'h00};
                n_pos = r_pos + 6'd1;
                if (r_pos == LAST_POS) begin
                    n_final = 1'b1;
                    w_rctl.load = 1'b1;
                    n_round = '0;
                    n_state = S_ROUND;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_idx == LAST_WORD) begin
                        n_h      = H_INIT;
                        n_cnt    = '0;
                        n_pos    = '0;
                        n_last   = 1'b0;
                        n_sent80 = 1'b0;
                        n_final  = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_h      <= H_INIT;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_round  <= '0;
            r_idx    <= '0;
            r_last   <= 1'b0;
            r_sent80 <= 1'b0;
            r_final  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_h      <= n_h;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_round  <= n_round;
            r_idx    <= n_idx;
            r_last   <= n_last;
            r_sent80 <= n_sent80;
            r_final  <= n_final;
        end
    end

    a_ready_not_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while digest items pending");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round <= LAST_ROUND))
        else $error("round counter out of range");

    a_len_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (r_pos[5:3] == 3'b111) && r_sent80)
        else $error("length bytes outside the last eight block bytes");

    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.final_word)
        |=> (r_h == H_INIT) && (r_cnt == 64'd0) && (r_pos == 6'd0))
        else $error("state not reinitialized after digest");

endmodule
